>>> hw/rtl/gs_pkg.sv
// Shared widths, constants and types of the galloping search block.
`timescale 1ns / 1ps

package gs_pkg;

    localparam int POS_W          = 12;   // entry position field
    localparam int ID_W           = 32;   // document id field
    localparam int LEN_W          = 13;   // list length register
    localparam int STEP_W         = 13;   // gallop step, saturates at 2**(STEP_W-1)
    localparam int DEF_LIST_DEPTH = 4096;

    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(1);
    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(2);

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
        logic [ID_W-1:0]  id;
    } t_result;

endpackage

>>> hw/rtl/gs_mem.sv
// Single write port, single read port id list memory with registered read data.
`timescale 1ns / 1ps

module gs_mem
    import gs_pkg::*;
#(
    parameter int DEPTH  = DEF_LIST_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [ID_W-1:0]   i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [ID_W-1:0]   o_rdata
);

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/gs_seq.sv
// Search sequencer: one compare unit and one probe/midpoint unit reused every cycle.
`timescale 1ns / 1ps

module gs_seq
    import gs_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH,
    parameter int ADDR_W     = $clog2(LIST_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [POS_W-1:0]  i_start_pos,
    input  logic [ID_W-1:0]   i_target,
    input  logic [LEN_W-1:0]  i_list_length,
    output logic              o_busy,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [ID_W-1:0]   i_rdata,
    output logic              o_res_valid,
    output t_result           o_res,
    input  logic              i_res_take
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RLAST  = 7'b0000010,
        S_CLAST  = 7'b0000100,
        S_CSTART = 7'b0001000,
        S_CGAL   = 7'b0010000,
        S_CBIN   = 7'b0100000,
        S_PUT    = 7'b1000000
    } t_state;

    localparam logic [31:0] DEPTH_W = 32'(LIST_DEPTH);

    t_state             r_state, n_state;
    logic [ID_W-1:0]    r_target, n_target;
    logic [POS_W-1:0]   r_start, n_start;
    logic [POS_W-1:0]   r_last, n_last;
    logic [POS_W-1:0]   r_lo, n_lo;
    logic [POS_W-1:0]   r_hi, n_hi;
    logic [POS_W-1:0]   r_mid, n_mid;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [ID_W-1:0]    r_hit_id, n_hit_id;
    t_result            r_res, n_res;

    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W-1:0]   eff_last;
    logic               rd_less;
    logic [POS_W-1:0]   rd_pos;

    // probe unit: next gallop position, clamped to the last entry
    logic [POS_W-1:0]   pr_lo;
    logic [STEP_W-1:0]  pr_step;
    logic [POS_W-1:0]   pr_room;
    logic [STEP_W-1:0]  pr_sum;
    logic [POS_W-1:0]   pr_hi;

    // midpoint unit: split of the half-open gap (lo, hi]
    logic [POS_W-1:0]   gp_lo;
    logic [POS_W-1:0]   gp_hi;
    logic [POS_W-1:0]   gp_size;
    logic [POS_W-1:0]   gp_mid;
    logic               gp_more;

    logic [POS_W+ADDR_W-1:0] rd_wide;

    assign eff_len  = ({19'd0, i_list_length} > DEPTH_W) ? LEN_W'(LIST_DEPTH) : i_list_length;
    assign eff_last = eff_len - LEN_W'(1);
    assign rd_less  = i_rdata < r_target;

    assign pr_room = r_last - pr_lo;
    assign pr_sum  = {1'b0, pr_lo} + pr_step;
    assign pr_hi   = ({1'b0, pr_room} < pr_step) ? r_last : pr_sum[POS_W-1:0];

    assign gp_size = gp_hi - gp_lo;
    assign gp_mid  = gp_lo + (gp_size >> 1);
    assign gp_more = gp_size > POS_W'(1);

    always_comb begin
        n_state  = r_state;
        n_target = r_target;
        n_start  = r_start;
        n_last   = r_last;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_step   = r_step;
        n_hit_id = r_hit_id;
        n_res    = r_res;
        rd_pos   = r_last;
        pr_lo    = r_start;
        pr_step  = STEP_FIRST;
        gp_lo    = r_lo;
        gp_hi    = r_hi;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_target = i_target;
                    n_start  = i_start_pos;
                    n_last   = eff_last[POS_W-1:0];
                    if (eff_len == '0 || {1'b0, i_start_pos} >= eff_len) begin
                        n_res   = '0;
                        n_state = S_PUT;
                    end else begin
                        n_state = S_RLAST;
                    end
                end
            end
            S_RLAST: begin
                rd_pos  = r_last;
                n_state = S_CLAST;
            end
            S_CLAST: begin
                rd_pos = r_start;
                if (rd_less) begin
                    n_res   = '0;
                    n_state = S_PUT;
                end else begin
                    n_state = S_CSTART;
                end
            end
            S_CSTART: begin
                pr_lo   = r_start;
                pr_step = STEP_FIRST;
                rd_pos  = pr_hi;
                if (!rd_less) begin
                    n_res   = '{found: 1'b1, pos: r_start, id: i_rdata};
                    n_state = S_PUT;
                end else begin
                    n_lo    = r_start;
                    n_hi    = pr_hi;
                    n_step  = STEP_FIRST;
                    n_state = S_CGAL;
                end
            end
            S_CGAL: begin
                pr_lo   = r_hi;
                pr_step = r_step[STEP_W-1] ? r_step : {r_step[STEP_W-2:0], 1'b0};
                gp_lo   = r_lo;
                gp_hi   = r_hi;
                if (rd_less) begin
                    // keep galloping from the probe that fell short
                    rd_pos  = pr_hi;
                    n_lo    = r_hi;
                    n_hi    = pr_hi;
                    n_step  = pr_step;
                end else begin
                    rd_pos   = gp_mid;
                    n_hit_id = i_rdata;
                    if (gp_more) begin
                        n_mid   = gp_mid;
                        n_state = S_CBIN;
                    end else begin
                        n_res   = '{found: 1'b1, pos: r_hi, id: i_rdata};
                        n_state = S_PUT;
                    end
                end
            end
            S_CBIN: begin
                if (rd_less) begin
                    gp_lo = r_mid;
                    gp_hi = r_hi;
                end else begin
                    gp_lo    = r_lo;
                    gp_hi    = r_mid;
                    n_hit_id = i_rdata;
                end
                rd_pos = gp_mid;
                n_lo   = gp_lo;
                n_hi   = gp_hi;
                n_mid  = gp_mid;
                if (!gp_more) begin
                    n_res   = '{found: 1'b1, pos: gp_hi, id: n_hit_id};
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        r_start  <= n_start;
        r_last   <= n_last;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_step   <= n_step;
        r_hit_id <= n_hit_id;
        r_res    <= n_res;
    end

    assign rd_wide     = {{ADDR_W{1'b0}}, rd_pos};
    assign o_raddr     = rd_wide[ADDR_W-1:0];
    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_PUT);
    assign o_res       = r_res;

endmodule

>>> hw/rtl/galloping_search_sorted_list.sv
// Top level: galloping search over one stored ascending list of document ids.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+---------------------------------------
//  input   | i_valid | o_stall | i_mode, i_position, i_doc_id
//  output  | o_valid | i_stall | o_found, o_new_position, o_found_id
//  config  | i_cfg_we| -       | i_cfg_wdata (list_length)
//
// A write transaction gives no result and does not stall the input. A search stalls the
// input through the start check (read of the last entry, then the compares at the last
// and start entries), then through its gallop probes and bisection steps, each bound by
// one read of the id memory, and through the hand-off of the result to the output
// register; the next transaction is taken only after that hand-off.
// Reset returns the sequencer to idle and sets list_length to 1; the id memory is not
// cleared. A finished result waits in the output register while the next transaction
// is taken; the sequencer holds its result while that register is full and stalled.
`timescale 1ns / 1ps

module galloping_search_sorted_list
    import gs_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_mode,
    input  logic [POS_W-1:0] i_position,
    input  logic [ID_W-1:0]  i_doc_id,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_found,
    output logic [POS_W-1:0] o_new_position,
    output logic [ID_W-1:0]  o_found_id
);

    localparam int          ADDR_W  = $clog2(LIST_DEPTH);
    localparam logic [31:0] DEPTH_W = 32'(LIST_DEPTH);

    logic [LEN_W-1:0]        r_list_length;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out;

    logic                    seq_busy;
    logic [ADDR_W-1:0]       seq_raddr;
    logic [ID_W-1:0]         mem_rdata;
    logic                    seq_res_valid;
    t_result                 seq_res;
    logic                    res_take;

    logic                    in_take;
    logic                    mem_we;
    logic [POS_W+ADDR_W-1:0] waddr_wide;

    assign in_take    = i_valid && !o_stall;
    assign mem_we     = in_take && (i_mode == MODE_WRITE) && ({20'd0, i_position} < DEPTH_W);
    assign waddr_wide = {{ADDR_W{1'b0}}, i_position};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_length <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_list_length <= i_cfg_wdata;
        end
    end

    gs_mem #(
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr_wide[ADDR_W-1:0]),
        .i_wdata (i_doc_id),
        .i_raddr (seq_raddr),
        .o_rdata (mem_rdata)
    );

    gs_seq #(
        .LIST_DEPTH (LIST_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_take && (i_mode == MODE_SEARCH)),
        .i_start_pos   (i_position),
        .i_target      (i_doc_id),
        .i_list_length (r_list_length),
        .o_busy        (seq_busy),
        .o_raddr       (seq_raddr),
        .i_rdata       (mem_rdata),
        .o_res_valid   (seq_res_valid),
        .o_res         (seq_res),
        .i_res_take    (res_take)
    );

    // load the output register when it is empty or being drained
    assign res_take = seq_res_valid && (!r_out_valid || !i_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_take) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= seq_res;
        end
    end

    assign o_stall        = seq_busy;
    assign o_valid        = r_out_valid;
    assign o_found        = r_out.found;
    assign o_new_position = r_out.pos;
    assign o_found_id     = r_out.id;

endmodule

>>> verif/tb.sv
// Self-checking bench for the galloping search block: directed table, then random list phases.
`timescale 1ns / 1ps

module tb;
    import gs_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int DRAIN_CYCLES = 40;    // longest search plus margin
    localparam int HOLD_CYCLES  = 500;   // one long receiver hold-off
    localparam int STUCK_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int N_DIRECTED   = 22;

    typedef enum logic [1:0] {ROW_WRITE, ROW_SEARCH, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [LEN_W-1:0] arg;     // position, or list length for ROW_CFG
        logic [ID_W-1:0]  id;
        logic             typed;   // expected result given in the row
        t_result          res;
    } t_row;

    localparam t_result MISS = '0;

    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{ROW_WRITE,  13'd0,    32'd100,        1'b0, MISS},
        '{ROW_WRITE,  13'd1,    32'd200,        1'b0, MISS},
        '{ROW_WRITE,  13'd2,    32'd300,        1'b0, MISS},
        '{ROW_WRITE,  13'd3,    32'hFFFF_FFFF,  1'b0, MISS},
        '{ROW_WRITE,  13'd4095, 32'd0,          1'b0, MISS},
        '{ROW_SEARCH, 13'd0,    32'd50,         1'b1, '{1'b1, 12'd0, 32'd100}},
        '{ROW_SEARCH, 13'd0,    32'd101,        1'b1, MISS},
        '{ROW_SEARCH, 13'd1,    32'd0,          1'b1, MISS},
        '{ROW_SEARCH, 13'd4095, 32'hFFFF_FFFF,  1'b1, MISS},
        '{ROW_CFG,    13'd0,    32'd0,          1'b0, MISS},
        '{ROW_SEARCH, 13'd0,    32'd0,          1'b1, MISS},
        '{ROW_CFG,    13'd4,    32'd0,          1'b0, MISS},
        '{ROW_SEARCH, 13'd0,    32'd250,        1'b0, MISS},
        '{ROW_SEARCH, 13'd0,    32'hFFFF_FFFF,  1'b1, '{1'b1, 12'd3, 32'hFFFF_FFFF}},
        '{ROW_SEARCH, 13'd3,    32'd0,          1'b1, '{1'b1, 12'd3, 32'hFFFF_FFFF}},
        '{ROW_SEARCH, 13'd1,    32'hFFFF_FFFF,  1'b0, MISS},
        '{ROW_WRITE,  13'd1,    32'd500,        1'b0, MISS},
        '{ROW_SEARCH, 13'd0,    32'd400,        1'b0, MISS},
        '{ROW_SEARCH, 13'd0,    32'd150,        1'b0, MISS},
        '{ROW_CFG,    13'h1FFF, 32'd0,          1'b0, MISS},
        '{ROW_SEARCH, 13'd4095, 32'd0,          1'b1, '{1'b1, 12'd4095, 32'd0}},
        '{ROW_SEARCH, 13'd4095, 32'd1,          1'b1, MISS}
    };

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [LEN_W-1:0] i_cfg_wdata = '0;
    logic             i_valid     = 1'b0;
    logic             o_stall;
    logic             i_mode      = MODE_WRITE;
    logic [POS_W-1:0] i_position  = '0;
    logic [ID_W-1:0]  i_doc_id    = '0;
    logic             o_valid;
    logic             i_stall     = 1'b1;
    logic             o_found;
    logic [POS_W-1:0] o_new_position;
    logic [ID_W-1:0]  o_found_id;

    // Mirror of the id list and the length register
    logic [ID_W-1:0]  list_ids [DEF_LIST_DEPTH];
    logic [LEN_W-1:0] list_len = LEN_RESET;

    t_result pending_hits [$];
    bit      failed    = 1'b0;
    bit      hold_req  = 1'b0;
    int      sent_count = 0;
    bit      send_burst = 1'b0;
    int      quiet_cycles = 0;

    galloping_search_sorted_list #(
        .LIST_DEPTH(DEF_LIST_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_position     (i_position),
        .i_doc_id       (i_doc_id),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found        (o_found),
        .o_new_position (o_new_position),
        .o_found_id     (o_found_id)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int unsigned active_length();
        return (list_len > DEF_LIST_DEPTH) ? DEF_LIST_DEPTH : int'(list_len);
    endfunction

    // First entry at or after start that reaches target: gallop, then bisect
    function automatic t_result gallop_lookup(input logic [POS_W-1:0] start,
                                              input logic [ID_W-1:0]  target);
        t_result     r;
        int unsigned n, last, lo, hi, step, mid;
        r = '0;
        n = active_length();
        if (n == 0 || start >= n)
            return r;
        last = n - 1;
        if (list_ids[last] < target)
            return r;
        hi = start;
        if (list_ids[start] < target) begin
            lo   = start;
            step = 2;
            forever begin
                hi = (last - lo < step) ? last : lo + step;
                if (list_ids[hi] >= target)
                    break;
                lo   = hi;
                step = step << 1;
            end
            while (hi - lo > 1) begin
                mid = lo + (hi - lo) / 2;
                if (list_ids[mid] < target)
                    lo = mid;
                else
                    hi = mid;
            end
        end
        r.found = 1'b1;
        r.pos   = hi[POS_W-1:0];
        r.id    = list_ids[hi];
        return r;
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_item(input logic             mode,
                             input logic [POS_W-1:0] pos,
                             input logic [ID_W-1:0]  id,
                             input bit               typed,
                             input t_result          typed_res);
        int gap;
        if (sent_count % 32 == 0)
            send_burst = ($urandom_range(0, 3) == 0);
        gap = send_burst ? 0 : $urandom_range(0, 13);
        sent_count++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= mode;
        i_position <= pos;
        i_doc_id   <= id;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        if (mode == MODE_WRITE)
            list_ids[pos] = id;
        else
            pending_hits = {pending_hits, (typed ? typed_res : gallop_lookup(pos, id))};
    endtask

    // Write list_length once the block has drained
    task automatic set_length(input logic [LEN_W-1:0] value);
        i_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        list_len  = value;
    endtask

    // Store an ascending id list in entries 0..n-1, optionally with a few strays
    task automatic fill_list(input int n, input bit jumble);
        logic [ID_W-1:0] next_id;
        int unsigned     span;
        bit              top_out;
        int              k;
        span    = 1 << $urandom_range(0, 19);
        next_id = ($urandom_range(0, 3) == 0) ? '0 : ID_W'($urandom_range(0, 1000));
        top_out = ($urandom_range(0, 3) == 0);
        for (k = 0; k < n; k++) begin
            if (top_out && k == n - 1)
                next_id = '1;
            send_item(MODE_WRITE, POS_W'(k), next_id, 1'b0, MISS);
            if (next_id > 32'hFFFF_FFFF - span)
                next_id = '1;
            else
                next_id += $urandom_range(0, span);
        end
        if (jumble) begin
            repeat ($urandom_range(1, 3))
                send_item(MODE_WRITE, POS_W'($urandom_range(0, n - 1)), $urandom, 1'b0, MISS);
        end
    endtask

    // Searches against the current list, with the odd stray write mixed in
    task automatic search_run(input int n);
        int unsigned      len;
        int               pick;
        logic [POS_W-1:0] start;
        logic [ID_W-1:0]  target;
        len = active_length();
        repeat (n) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(MODE_WRITE, POS_W'($urandom_range(0, 4095)), $urandom, 1'b0, MISS);
            end else begin
                if (len == 0 || $urandom_range(0, 7) == 0)
                    start = POS_W'($urandom_range(0, 4095));
                else
                    start = POS_W'($urandom_range(0, len - 1));
                pick = $urandom_range(0, 9);
                if (len == 0)
                    target = $urandom;
                else if (pick < 4)
                    target = list_ids[$urandom_range(0, len - 1)];
                else if (pick < 6)
                    target = list_ids[$urandom_range(0, len - 1)] + 1'b1;
                else if (pick == 6)
                    target = '0;
                else if (pick == 7)
                    target = '1;
                else
                    target = $urandom;
                send_item(MODE_SEARCH, start, target, 1'b0, MISS);
            end
        end
    endtask

    initial begin
        int unsigned      base;
        int               phase;
        int               pick;
        logic [LEN_W-1:0] new_len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            case (DIRECTED[r].kind)
                ROW_CFG: set_length(DIRECTED[r].arg);
                ROW_WRITE: send_item(MODE_WRITE, DIRECTED[r].arg[POS_W-1:0], DIRECTED[r].id,
                                     1'b0, MISS);
                default: send_item(MODE_SEARCH, DIRECTED[r].arg[POS_W-1:0], DIRECTED[r].id,
                                   DIRECTED[r].typed, DIRECTED[r].res);
            endcase
        end

        // Each phase fills every entry that its searches can reach
        base  = sent_count;
        phase = 0;
        while (sent_count - base < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                new_len = '0;
            else if (pick == 1)
                new_len = LEN_W'(1);
            else if (pick < 14)
                new_len = LEN_W'($urandom_range(2, 40));
            else
                new_len = LEN_W'($urandom_range(41, 200));
            set_length(new_len);
            if (new_len != 0)
                fill_list(new_len, $urandom_range(0, 3) == 0);
            if (phase == 3)
                hold_req = 1'b1;
            search_run(phase == 3 ? 80 : $urandom_range(10, 40));
            phase++;
        end

        i_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result side: random stall before each transaction, one long hold-off
    initial begin
        int      gap;
        int      taken;
        bit      recv_burst;
        t_result want;
        taken      = 0;
        recv_burst = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 32 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            gap = recv_burst ? 0 : $urandom_range(0, 13);
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
            taken++;
            if (pending_hits.size() == 0) begin
                $error("unexpected result: found=%0b new_position=%0d found_id=%08h",
                       o_found, o_new_position, o_found_id);
                failed = 1'b1;
            end else begin
                want = pending_hits.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, o_found);
                    failed = 1'b1;
                end
                if (o_new_position !== want.pos) begin
                    $error("new_position: expected %0d, got %0d", want.pos, o_new_position);
                    failed = 1'b1;
                end
                if (o_found_id !== want.id) begin
                    $error("found_id: expected %08h, got %08h", want.id, o_found_id);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STUCK_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
